// ----- hw/rtl/lspr_pkg.sv -----
package lspr_pkg;

  localparam int unsigned VALUE_W    = 16;
  localparam int unsigned SIDE_W     = 5;
  localparam int unsigned DIM_W      = 5;
  localparam int unsigned POS_W      = 4;
  localparam int unsigned AREA_W     = 9;
  localparam int unsigned MIN_DIM    = 2;
  localparam logic [SIDE_W-1:0] SIDE_RESET = 5'd16;

endpackage

// ----- hw/rtl/largest_same_parity_rectangle.sv -----
// Channel  | Handshake                    | Payload
// ---------+------------------------------+---------------------------------------
// in       | start_i high, busy_o low     | value_i
// out      | done_o, one cycle, no stall  | found_o width_o height_o top_row_o
//          |                              | left_col_o area_o
// cfg      | cfg_valid_i and cfg_ready_o  | cfg_side_i
//
// Loading accepts one item per cycle while busy_o is low; a whole row of parity
// bits is written to the map RAM on its last item. After the last item of a
// matrix the search sequencer runs a RAM read and a window compare per tested
// (row, column, width, height) step, then presents the result; busy_o stays high
// meanwhile. Reset clears the counters and the search state and sets side to 16;
// the map needs none. The receiver cannot stall; a config write restarts the load.
module largest_same_parity_rectangle import lspr_pkg::*; #(
  parameter int unsigned MAX_SIDE = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic signed [VALUE_W-1:0] value_i,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [SIDE_W-1:0]         cfg_side_i,
  output logic                      done_o,
  output logic                      found_o,
  output logic [DIM_W-1:0]          width_o,
  output logic [DIM_W-1:0]          height_o,
  output logic [POS_W-1:0]          top_row_o,
  output logic [POS_W-1:0]          left_col_o,
  output logic [AREA_W-1:0]         area_o
);

  localparam int unsigned SW = $clog2(MAX_SIDE + 1);
  localparam int unsigned IW = $clog2(MAX_SIDE);
  localparam int unsigned AW = $clog2(MAX_SIDE * MAX_SIDE + 1);
  localparam int unsigned NW = (SW > SIDE_W) ? SW : SIDE_W;

  logic [SIDE_W-1:0]   side_q;
  logic [NW-1:0]       side_x;
  logic [SW-1:0]       n;
  logic                cfg_wr;
  logic                accept;
  logic                wr_en;
  logic [IW-1:0]       wr_addr;
  logic [MAX_SIDE-1:0] wr_data;
  logic                rd_en;
  logic [IW-1:0]       rd_addr;
  logic [MAX_SIDE-1:0] rd_data;
  logic                last;

  assign cfg_ready_o = !busy_o;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign accept      = start_i && !busy_o;

  assign side_x = NW'(side_q);
  assign n = (side_x == '0)            ? SW'(1) :
             (side_x > NW'(MAX_SIDE))  ? SW'(MAX_SIDE) :
                                         SW'(side_x);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= SIDE_RESET;
    end else if (cfg_wr) begin
      side_q <= cfg_side_i;
    end
  end

  lspr_loader #(
    .MAX_SIDE (MAX_SIDE),
    .SW       (SW),
    .IW       (IW)
  ) u_loader (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (cfg_wr),
    .accept_i  (accept),
    .bit_i     (value_i[0]),
    .n_i       (n),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data),
    .last_o    (last)
  );

  lspr_ram #(
    .WIDTH (MAX_SIDE),
    .DEPTH (MAX_SIDE)
  ) u_map (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  lspr_search #(
    .MAX_SIDE (MAX_SIDE),
    .SW       (SW),
    .IW       (IW),
    .AW       (AW)
  ) u_search (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (last),
    .n_i        (n),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data),
    .busy_o     (busy_o),
    .done_o     (done_o),
    .found_o    (found_o),
    .width_o    (width_o),
    .height_o   (height_o),
    .top_row_o  (top_row_o),
    .left_col_o (left_col_o),
    .area_o     (area_o)
  );

endmodule

// ----- hw/rtl/lspr_ram.sv -----
module lspr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

// ----- hw/rtl/lspr_loader.sv -----
module lspr_loader import lspr_pkg::*; #(
  parameter int unsigned MAX_SIDE = 16,
  parameter int unsigned SW       = $clog2(MAX_SIDE + 1),
  parameter int unsigned IW       = $clog2(MAX_SIDE)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                clr_i,
  input  logic                accept_i,
  input  logic                bit_i,
  input  logic [SW-1:0]       n_i,
  output logic                wr_en_o,
  output logic [IW-1:0]       wr_addr_o,
  output logic [MAX_SIDE-1:0] wr_data_o,
  output logic                last_o
);

  logic [IW-1:0]       r_q, r_d;
  logic [IW-1:0]       c_q, c_d;
  logic [MAX_SIDE-1:0] rowbuf_q;
  logic [MAX_SIDE-1:0] row_now;
  logic                last_col;
  logic                last_row;

  always_comb begin
    row_now      = rowbuf_q;
    row_now[c_q] = bit_i;
  end

  assign last_col  = SW'(c_q) == n_i - SW'(1);
  assign last_row  = SW'(r_q) == n_i - SW'(1);
  assign wr_en_o   = accept_i && last_col;
  assign wr_addr_o = r_q;
  assign wr_data_o = row_now;
  assign last_o    = accept_i && last_col && last_row;

  always_comb begin
    r_d = r_q;
    c_d = c_q;
    if (clr_i) begin
      r_d = '0;
      c_d = '0;
    end else if (accept_i) begin
      if (last_col) begin
        c_d = '0;
        r_d = last_row ? '0 : r_q + IW'(1);
      end else begin
        c_d = c_q + IW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q <= '0;
      c_q <= '0;
    end else begin
      r_q <= r_d;
      c_q <= c_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      rowbuf_q <= row_now;
    end
  end

endmodule

// ----- hw/rtl/lspr_search.sv -----
module lspr_search import lspr_pkg::*; #(
  parameter int unsigned MAX_SIDE = 16,
  parameter int unsigned SW       = $clog2(MAX_SIDE + 1),
  parameter int unsigned IW       = $clog2(MAX_SIDE),
  parameter int unsigned AW       = $clog2(MAX_SIDE * MAX_SIDE + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                go_i,
  input  logic [SW-1:0]       n_i,
  output logic                rd_en_o,
  output logic [IW-1:0]       rd_addr_o,
  input  logic [MAX_SIDE-1:0] rd_data_i,
  output logic                busy_o,
  output logic                done_o,
  output logic                found_o,
  output logic [DIM_W-1:0]    width_o,
  output logic [DIM_W-1:0]    height_o,
  output logic [POS_W-1:0]    top_row_o,
  output logic [POS_W-1:0]    left_col_o,
  output logic [AREA_W-1:0]   area_o
);

  localparam int unsigned XW = SW + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_DONE
  } state_e;

  state_e        state_q;
  logic [SW-1:0] n_q;
  logic [IW-1:0] r_q, c_q, rrow_q;
  logic [SW-1:0] w_q, h_q;
  logic [AW-1:0] acc_q;
  logic          p_q;
  logic [SW-1:0] best_w_q, best_h_q;
  logic [IW-1:0] best_r_q, best_c_q;
  logic [AW-1:0] best_area_q;

  logic [MAX_SIDE-1:0] mask;
  logic [XW-1:0]       c_x, w_x, r_x, n_x, hi_x;
  logic                p_cur, ok, better, grow, w_fit, c_fit, r_fit;
  logic [AW-1:0]       area_nx;

  assign c_x  = XW'(c_q);
  assign w_x  = XW'(w_q);
  assign r_x  = XW'(r_q);
  assign n_x  = XW'(n_q);
  assign hi_x = c_x + w_x;

  always_comb begin
    for (int i = 0; i < MAX_SIDE; i++) begin
      mask[i] = (XW'(i) >= c_x) && (XW'(i) < hi_x);
    end
  end

  assign p_cur   = (h_q == SW'(1)) ? rd_data_i[c_q] : p_q;
  assign ok      = ((rd_data_i ^ {MAX_SIDE{p_cur}}) & mask) == '0;
  assign area_nx = acc_q + AW'(w_q);
  assign better  = ok && (h_q >= SW'(MIN_DIM)) && (area_nx > best_area_q);
  assign grow    = ok && (XW'(rrow_q) + XW'(1) < n_x);
  assign w_fit   = hi_x + XW'(1) <= n_x;
  assign c_fit   = c_x + XW'(MIN_DIM + 1) <= n_x;
  assign r_fit   = r_x + XW'(MIN_DIM + 1) <= n_x;

  assign rd_en_o   = state_q == S_READ;
  assign rd_addr_o = rrow_q;
  assign busy_o    = state_q != S_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      n_q         <= '0;
      r_q         <= '0;
      c_q         <= '0;
      rrow_q      <= '0;
      w_q         <= '0;
      h_q         <= '0;
      acc_q       <= '0;
      p_q         <= 1'b0;
      best_w_q    <= '0;
      best_h_q    <= '0;
      best_r_q    <= '0;
      best_c_q    <= '0;
      best_area_q <= '0;
      done_o      <= 1'b0;
      found_o     <= 1'b0;
      width_o     <= '0;
      height_o    <= '0;
      top_row_o   <= '0;
      left_col_o  <= '0;
      area_o      <= '0;
    end else begin
      done_o <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (go_i) begin
            n_q         <= n_i;
            r_q         <= '0;
            c_q         <= '0;
            rrow_q      <= '0;
            w_q         <= SW'(MIN_DIM);
            h_q         <= SW'(1);
            acc_q       <= '0;
            best_w_q    <= '0;
            best_h_q    <= '0;
            best_r_q    <= '0;
            best_c_q    <= '0;
            best_area_q <= '0;
            state_q     <= (n_i >= SW'(MIN_DIM)) ? S_READ : S_DONE;
          end
        end
        S_READ: begin
          state_q <= S_CHECK;
        end
        S_CHECK: begin
          p_q <= p_cur;
          if (better) begin
            best_w_q    <= w_q;
            best_h_q    <= h_q;
            best_r_q    <= r_q;
            best_c_q    <= c_q;
            best_area_q <= area_nx;
          end
          if (grow) begin
            h_q     <= h_q + SW'(1);
            rrow_q  <= rrow_q + IW'(1);
            acc_q   <= area_nx;
            state_q <= S_READ;
          end else if (w_fit) begin
            w_q     <= w_q + SW'(1);
            h_q     <= SW'(1);
            rrow_q  <= r_q;
            acc_q   <= '0;
            state_q <= S_READ;
          end else if (c_fit) begin
            c_q     <= c_q + IW'(1);
            w_q     <= SW'(MIN_DIM);
            h_q     <= SW'(1);
            rrow_q  <= r_q;
            acc_q   <= '0;
            state_q <= S_READ;
          end else if (r_fit) begin
            r_q     <= r_q + IW'(1);
            c_q     <= '0;
            w_q     <= SW'(MIN_DIM);
            h_q     <= SW'(1);
            rrow_q  <= r_q + IW'(1);
            acc_q   <= '0;
            state_q <= S_READ;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          done_o     <= 1'b1;
          found_o    <= best_area_q != '0;
          width_o    <= DIM_W'(best_w_q);
          height_o   <= DIM_W'(best_h_q);
          top_row_o  <= POS_W'(best_r_q);
          left_col_o <= POS_W'(best_c_q);
          area_o     <= AREA_W'(best_area_q);
          state_q    <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_best_area_product: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (2*SW)'(best_area_q) == (2*SW)'(best_w_q) * (2*SW)'(best_h_q))
    else $error("best area differs from width times height");

  a_acc_tracks_height: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CHECK |->
      (2*SW)'(acc_q) == (2*SW)'(w_q) * ((2*SW)'(h_q) - (2*SW)'(1)))
    else $error("area accumulator out of step with height");

  a_window_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CHECK |-> (hi_x <= n_x) && (XW'(rrow_q) < n_x))
    else $error("window leaves the loaded matrix");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_found_area: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (found_o == (area_o != '0)))
    else $error("found flag disagrees with area");
`endif

endmodule
